/* design/p2fb_pkg.sv */
package p2fb_pkg;

  localparam int CMD_W   = 3;
  localparam int COORD_W = 16;
  localparam int COLOR_W = 2;
  // signed working width for coordinate math (16-bit inputs plus flip/offset growth)
  localparam int CALC_W  = 18;

  localparam logic [CMD_W-1:0] CMD_WRITE = 3'd0;
  localparam logic [CMD_W-1:0] CMD_READ  = 3'd1;
  localparam logic [CMD_W-1:0] CMD_FILL  = 3'd2;
  localparam logic [CMD_W-1:0] CMD_HLINE = 3'd3;
  localparam logic [CMD_W-1:0] CMD_VLINE = 3'd4;

  localparam logic [1:0] REG_WIDTH    = 2'd0;
  localparam logic [1:0] REG_HEIGHT   = 2'd1;
  localparam logic [1:0] REG_ROTATION = 2'd2;

  typedef logic [7:0] mask_arr_t [4];
  localparam mask_arr_t CLEAR_MASK = '{8'hFC, 8'hF3, 8'hCF, 8'h3F};

endpackage

/* design/p2fb_cmd_if.sv */
interface p2fb_cmd_if;
  logic                              valid;
  logic                              ready;
  logic [p2fb_pkg::CMD_W-1:0]        command;
  logic signed [p2fb_pkg::COORD_W-1:0] pos_x;
  logic signed [p2fb_pkg::COORD_W-1:0] pos_y;
  logic signed [p2fb_pkg::COORD_W-1:0] span;
  logic [p2fb_pkg::COLOR_W-1:0]      pixel_color;

  modport source (output valid, command, pos_x, pos_y, span, pixel_color, input ready);
  modport sink   (input valid, command, pos_x, pos_y, span, pixel_color, output ready);
  modport monitor (input valid, ready, command, pos_x, pos_y, span, pixel_color);
endinterface

/* design/p2fb_res_if.sv */
interface p2fb_res_if;
  logic                         valid;
  logic                         ready;
  logic [p2fb_pkg::COLOR_W-1:0] read_value;
  logic                         drew_any;

  modport source (output valid, read_value, drew_any, input ready);
  modport sink   (input valid, read_value, drew_any, output ready);
  modport monitor (input valid, ready, read_value, drew_any);
endinterface

/* design/p2fb_map.sv */
module p2fb_map #(
  parameter int WW  = 9,
  parameter int HW  = 7,
  parameter int RXW = 8,
  parameter int RYW = 6
) (
  input  logic signed [p2fb_pkg::CALC_W-1:0] px,
  input  logic signed [p2fb_pkg::CALC_W-1:0] py,
  input  logic [WW-1:0]                      eff_w,
  input  logic [HW-1:0]                      eff_h,
  input  logic [1:0]                         rotation,
  output logic                               ok,
  output logic [RXW-1:0]                     rx,
  output logic [RYW-1:0]                     ry
);

  logic signed [p2fb_pkg::CALC_W-1:0] w_s;
  logic signed [p2fb_pkg::CALC_W-1:0] h_s;
  logic signed [p2fb_pkg::CALC_W-1:0] a;
  logic signed [p2fb_pkg::CALC_W-1:0] b;

  assign w_s = p2fb_pkg::CALC_W'(eff_w);
  assign h_s = p2fb_pkg::CALC_W'(eff_h);

  always_comb begin
    case (rotation)
      2'd1: begin
        a = w_s - 18'sd1 - py;
        b = px;
      end
      2'd2: begin
        a = w_s - 18'sd1 - px;
        b = h_s - 18'sd1 - py;
      end
      2'd3: begin
        a = py;
        b = h_s - 18'sd1 - px;
      end
      default: begin
        a = px;
        b = py;
      end
    endcase
  end

  assign ok = (a >= 0) && (b >= 0) && (a < w_s) && (b < h_s);
  assign rx = a[RXW-1:0];
  assign ry = b[RYW-1:0];

endmodule

/* design/packed_2bpp_framebuffer_drawer.sv */
// Channel  Dir  Handshake          Payload
// cmd      in   valid/ready        command, pos_x, pos_y, span, pixel_color
// res      out  valid/ready        read_value, drew_any
// cfg      in   cfg_we (no ready)  cfg_index, cfg_data
//
// Steps, from the accept through the result:
//   write or read pixel: accept, setup, map, read, write, result; off canvas the
//   map goes straight to the result; unknown command: accept, setup, result.
// Lines: loop, map, read, write per clipped position; a position that maps
//   off canvas takes only loop and map.
// Fill: ((W+3)/4)*H bytes, one byte per cycle through the single write port.
// Reset: a clearing pass zeroes the store, one byte a cycle, STORE bytes
//   (4096 at default size); no request is taken meanwhile.
// Stalls: the result sits in an output register; the sequencer waits there only
//   if the previous result has not been taken yet.
module packed_2bpp_framebuffer_drawer #(
  parameter int MAX_WIDTH  = 256,
  parameter int MAX_HEIGHT = 64
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       cfg_we,
  input  logic [1:0] cfg_index,
  input  logic [8:0] cfg_data,
  p2fb_cmd_if.sink   cmd,
  p2fb_res_if.source res
);

  localparam int RB_MAX = (MAX_WIDTH + 3) / 4;
  localparam int STORE  = RB_MAX * MAX_HEIGHT;
  localparam int AW     = (STORE > 1) ? $clog2(STORE) : 1;
  localparam int FW     = $clog2(STORE + 1);
  localparam int WW     = $clog2(MAX_WIDTH + 1);
  localparam int HW     = $clog2(MAX_HEIGHT + 1);
  localparam int RBW    = $clog2(RB_MAX + 1);
  localparam int LMAX   = (MAX_WIDTH > MAX_HEIGHT) ? MAX_WIDTH : MAX_HEIGHT;
  localparam int LW     = $clog2(LMAX + 1);
  localparam int RXW    = $clog2(MAX_WIDTH);
  localparam int RYW    = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
  localparam int CW     = p2fb_pkg::CALC_W;

  // sequencer states
  localparam logic [2:0] S_CLEAR = 3'd0;
  localparam logic [2:0] S_IDLE  = 3'd1;
  localparam logic [2:0] S_SETUP = 3'd2;
  localparam logic [2:0] S_LOOP  = 3'd3;
  localparam logic [2:0] S_MAP   = 3'd4;
  localparam logic [2:0] S_RD    = 3'd5;
  localparam logic [2:0] S_WR    = 3'd6;
  localparam logic [2:0] S_FILL  = 3'd7;
  // no separate result state: the done flag, held in IDLE, marks a pending result
  logic [2:0] state;
  logic       done;

  // configuration
  logic [8:0] canvas_width;
  logic [6:0] canvas_height;
  logic [1:0] rotation;

  always_ff @(posedge clk) begin
    if (rst) begin
      canvas_width  <= 9'd256;
      canvas_height <= 7'd64;
      rotation      <= 2'd0;
    end else if (cfg_we) begin
      case (cfg_index)
        p2fb_pkg::REG_WIDTH:    canvas_width  <= cfg_data;
        p2fb_pkg::REG_HEIGHT:   canvas_height <= cfg_data[6:0];
        p2fb_pkg::REG_ROTATION: rotation      <= cfg_data[1:0];
        default: ;
      endcase
    end
  end

  // effective sizes, clamped to the store geometry
  logic [WW-1:0]  eff_w;
  logic [HW-1:0]  eff_h;
  logic [RBW-1:0] row_bytes;
  logic [LW-1:0]  log_w;
  logic [LW-1:0]  log_h;

  assign eff_w = (32'(canvas_width) > 32'(MAX_WIDTH)) ? WW'(MAX_WIDTH) : WW'(canvas_width);
  assign eff_h = (32'(canvas_height) > 32'(MAX_HEIGHT)) ? HW'(MAX_HEIGHT) : HW'(canvas_height);
  assign row_bytes = RBW'((32'(eff_w) + 32'd3) >> 2);
  assign log_w = rotation[0] ? LW'(eff_h) : LW'(eff_w);
  assign log_h = rotation[0] ? LW'(eff_w) : LW'(eff_h);

  // latched request
  logic [p2fb_pkg::CMD_W-1:0]   q_cmd;
  logic signed [CW-1:0]         q_x;
  logic signed [CW-1:0]         q_y;
  logic signed [CW-1:0]         q_span;
  logic [p2fb_pkg::COLOR_W-1:0] q_color;

  // working registers
  logic signed [CW-1:0] px;
  logic signed [CW-1:0] py;
  logic [LW-1:0]        cur;
  logic [LW-1:0]        stop;
  logic [RXW-1:0]       m_rx;
  logic [RYW-1:0]       m_ry;
  logic [FW-1:0]        cnt;
  logic [FW-1:0]        fill_n;
  logic                 drew;
  logic [1:0]           rd_val;
  logic                 is_line;

  // line clipping (setup cycle)
  logic                 vert;
  logic signed [CW-1:0] s0;
  logic signed [CW-1:0] s1;
  logic signed [CW-1:0] mag;
  logic signed [CW-1:0] hi;
  logic signed [CW-1:0] lo;
  logic signed [CW-1:0] lim;
  logic [LW-1:0]        lo_c;
  logic [LW-1:0]        hi_c;

  always_comb begin
    vert = (q_cmd == p2fb_pkg::CMD_VLINE);
    s0   = vert ? q_y : q_x;
    lim  = vert ? CW'(log_h) : CW'(log_w);
    if (q_span < 0) begin
      s1  = s0 + q_span + 18'sd1;
      mag = -q_span;
    end else begin
      s1  = s0;
      mag = q_span;
    end
    hi = s1 + mag;
    lo = (s1 < 0) ? 18'sd0 : s1;
    if (hi > lim)      hi_c = LW'(lim);
    else if (hi < 0)   hi_c = '0;
    else               hi_c = LW'(hi);
    lo_c = (lo > lim) ? LW'(lim) : LW'(lo);
  end

  // shared coordinate mapper
  logic           map_ok;
  logic [RXW-1:0] map_rx;
  logic [RYW-1:0] map_ry;

  p2fb_map #(.WW(WW), .HW(HW), .RXW(RXW), .RYW(RYW)) u_map (
    .px       (px),
    .py       (py),
    .eff_w    (eff_w),
    .eff_h    (eff_h),
    .rotation (rotation),
    .ok       (map_ok),
    .rx       (map_rx),
    .ry       (map_ry)
  );

  // pixel store: one write port, one registered read port
  logic [7:0]    mem [STORE];
  logic [7:0]    rdata;
  logic [AW-1:0] pix_addr;
  logic          mem_we;
  logic [AW-1:0] mem_waddr;
  logic [7:0]    mem_wdata;
  logic [3:0]    shift;
  logic [7:0]    merged;

  assign pix_addr = AW'(32'(m_rx >> 2) + 32'(m_ry) * 32'(row_bytes));
  assign shift    = {1'b0, m_rx[1:0], 1'b0};
  assign merged   = (rdata & p2fb_pkg::CLEAR_MASK[m_rx[1:0]]) | (8'(q_color) << shift);

  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = pix_addr;
    mem_wdata = merged;
    case (state)
      S_CLEAR: begin
        mem_we    = 1'b1;
        mem_waddr = cnt[AW-1:0];
        mem_wdata = 8'h00;
      end
      S_FILL: begin
        mem_we    = (cnt < fill_n);
        mem_waddr = cnt[AW-1:0];
        mem_wdata = {4{q_color}};
      end
      S_WR: begin
        mem_we = (q_cmd != p2fb_pkg::CMD_READ);
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (mem_we) mem[mem_waddr] <= mem_wdata;
    rdata <= mem[pix_addr];
  end

  // handshakes
  logic res_valid;
  logic [1:0] res_rd;
  logic res_drew;

  assign cmd.ready      = (state == S_IDLE) && !done;
  assign res.valid      = res_valid;
  assign res.read_value = res_rd;
  assign res.drew_any   = res_drew;

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (done && (!res_valid || res.ready)) begin
      res_valid <= 1'b1;
    end else if (res.ready) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (done && (!res_valid || res.ready)) begin
      res_rd   <= rd_val;
      res_drew <= drew;
    end
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
      done  <= 1'b0;
      cnt   <= '0;
    end else begin
      case (state)
        S_CLEAR: begin
          cnt <= cnt + 1'b1;
          if (cnt == FW'(STORE - 1)) state <= S_IDLE;
        end
        S_IDLE: begin
          if (done) begin
            if (!res_valid || res.ready) done <= 1'b0;
          end else if (cmd.valid) begin
            state <= S_SETUP;
          end
        end
        S_SETUP: begin
          cnt <= '0;
          case (q_cmd)
            p2fb_pkg::CMD_WRITE, p2fb_pkg::CMD_READ: state <= S_MAP;
            p2fb_pkg::CMD_FILL:                      state <= S_FILL;
            p2fb_pkg::CMD_HLINE, p2fb_pkg::CMD_VLINE: state <= S_LOOP;
            default: begin
              state <= S_IDLE;
              done  <= 1'b1;
            end
          endcase
        end
        S_LOOP: begin
          if (cur < stop) begin
            state <= S_MAP;
          end else begin
            state <= S_IDLE;
            done  <= 1'b1;
          end
        end
        S_MAP: begin
          if (map_ok) begin
            state <= S_RD;
          end else if (is_line) begin
            state <= S_LOOP;
          end else begin
            state <= S_IDLE;
            done  <= 1'b1;
          end
        end
        S_RD: state <= S_WR;
        S_WR: begin
          if (is_line) begin
            state <= S_LOOP;
          end else begin
            state <= S_IDLE;
            done  <= 1'b1;
          end
        end
        S_FILL: begin
          cnt <= cnt + 1'b1;
          if (cnt >= fill_n) begin
            state <= S_IDLE;
            done  <= 1'b1;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    case (state)
      S_IDLE: begin
        if (!done && cmd.valid) begin
          q_cmd   <= cmd.command;
          q_x     <= CW'(cmd.pos_x);
          q_y     <= CW'(cmd.pos_y);
          q_span  <= CW'(cmd.span);
          q_color <= cmd.pixel_color;
          drew    <= 1'b0;
          rd_val  <= 2'd0;
        end
      end
      S_SETUP: begin
        px      <= q_x;
        py      <= q_y;
        cur     <= lo_c;
        stop    <= hi_c;
        is_line <= (q_cmd == p2fb_pkg::CMD_HLINE) || (q_cmd == p2fb_pkg::CMD_VLINE);
        fill_n  <= FW'(32'(row_bytes) * 32'(eff_h));
      end
      S_LOOP: begin
        if (q_cmd == p2fb_pkg::CMD_VLINE) begin
          px <= q_x;
          py <= CW'(cur);
        end else begin
          px <= CW'(cur);
          py <= q_y;
        end
      end
      S_MAP: begin
        m_rx <= map_rx;
        m_ry <= map_ry;
        if (!map_ok) cur <= cur + 1'b1;
      end
      S_WR: begin
        cur <= cur + 1'b1;
        if (q_cmd == p2fb_pkg::CMD_READ) rd_val <= 2'(rdata >> shift);
        else                              drew   <= 1'b1;
      end
      S_FILL: begin
        if (cnt >= fill_n) drew <= (fill_n != '0);
      end
      default: ;
    endcase
  end

endmodule
